>>> hw/rtl/utf16_name_to_escaped_file_name_defines.svh
// assertion macros for the utf-16 name to escaped file name block
`ifndef UTF16_NAME_TO_ESCAPED_FILE_NAME_DEFINES_SVH
`define UTF16_NAME_TO_ESCAPED_FILE_NAME_DEFINES_SVH
`ifndef SYNTH
`define U16FN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u16fn assertion failed");
`define U16FN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u16fn assertion failed");
`else
`define U16FN_ASSERT_IMP(lbl, ante, cons)
`define U16FN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/u16fn_pkg.sv
// shared types, constants and helpers of the escaped file name block
`default_nettype none
package u16fn_pkg;
	localparam int CuW  = 16;
	localparam int ChW  = 8;
	localparam int CpW  = 21;
	localparam int CntW = 9;

	localparam logic [63:0]    FnvBasis   = 64'hCBF29CE484222325;
	localparam logic [CpW-1:0] CpRepl     = 21'h00FFFD;
	localparam logic [CpW-1:0] CpSuppBase = 21'h010000;
	localparam logic [7:0]     LimReset   = 8'd180;

	localparam logic [ChW-1:0] ChPct   = 8'h25;
	localparam logic [ChW-1:0] ChTilde = 8'h7E;
	localparam logic [ChW-1:0] ChDot   = 8'h2E;
	localparam logic [ChW-1:0] ChD     = 8'h64;
	localparam logic [ChW-1:0] ChB     = 8'h62;

	// one request from the sequencer to the output stage
	typedef struct packed {
		logic           push;
		logic           fin;
		logic           nc_end;
		logic [ChW-1:0] ch;
	} out_req_t;

	// hash register operations
	typedef struct packed {
		logic clr;
		logic upd;
		logic shl;
	} hash_op_t;

	function automatic logic [ChW-1:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'b0, n}) : (8'h37 + {4'b0, n});
	endfunction

	function automatic logic is_plain(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F;
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/u16fn_esc.sv
// utf-8 byte selection and percent escape character unit
`default_nettype none
module u16fn_esc (
	input  wire logic [u16fn_pkg::CpW-1:0] cp,
	input  wire logic [1:0]                nb_m1,
	input  wire logic [1:0]                bi,
	input  wire logic [1:0]                ci,
	output logic [7:0]                     byte_val,
	output logic [u16fn_pkg::ChW-1:0]      ch,
	output logic                           byte_done
);
	import u16fn_pkg::*;

	logic plain;

	always_comb begin
		case (nb_m1)
			2'd0: byte_val = cp[7:0];
			2'd1: byte_val = (bi == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			2'd2: begin
				case (bi)
					2'd0:    byte_val = {4'b1110, cp[15:12]};
					2'd1:    byte_val = {2'b10, cp[11:6]};
					default: byte_val = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (bi)
					2'd0:    byte_val = {5'b11110, cp[20:18]};
					2'd1:    byte_val = {2'b10, cp[17:12]};
					2'd2:    byte_val = {2'b10, cp[11:6]};
					default: byte_val = {2'b10, cp[5:0]};
				endcase
			end
		endcase
	end

	assign plain = is_plain(byte_val);

	always_comb begin
		if (plain) begin
			ch = byte_val;
		end else begin
			case (ci)
				2'd0:    ch = ChPct;
				2'd1:    ch = hex_char(byte_val[7:4]);
				default: ch = hex_char(byte_val[3:0]);
			endcase
		end
	end

	assign byte_done = plain || (ci == 2'd2);
endmodule
`default_nettype wire

>>> hw/rtl/u16fn_hash.sv
// fnv-1a 64-bit hash register with nibble readout by shifting
`default_nettype none
module u16fn_hash (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire u16fn_pkg::hash_op_t op,
	input  wire logic [7:0]          byte_val,
	output logic [3:0]               nib
);
	import u16fn_pkg::*;

	logic [63:0] hash_q;
	logic [63:0] x;
	logic [63:0] prod;

	// prime is 2^40 + 0x1b3
	assign x    = hash_q ^ {56'b0, byte_val};
	assign prod = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	assign nib  = hash_q[63:60];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FnvBasis;
		end else if (op.clr) begin
			hash_q <= FnvBasis;
		end else if (op.upd) begin
			hash_q <= prod;
		end else if (op.shl) begin
			hash_q <= {hash_q[59:0], 4'b0};
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/u16fn_out.sv
// one-char hold stage and output register, marks the final char of each item
`default_nettype none
module u16fn_out (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire u16fn_pkg::out_req_t       req,
	input  wire logic                      tready,
	output logic                           adv,
	output logic                           pend_busy,
	output logic                           tvalid,
	output logic [u16fn_pkg::ChW-1:0]      tdata,
	output logic                           tlast,
	output logic                           tuser
);
	import u16fn_pkg::*;

	logic           pend_v_q;
	logic [ChW-1:0] pend_ch_q;
	logic           out_v_q;
	logic [ChW-1:0] out_ch_q;
	logic           out_last_q;
	logic           out_nc_q;
	logic           move;

	assign adv       = !(pend_v_q && out_v_q && !tready);
	assign move      = adv && pend_v_q && (req.push || req.fin);
	assign pend_busy = pend_v_q;
	assign tvalid    = out_v_q;
	assign tdata     = out_ch_q;
	assign tlast     = out_last_q;
	assign tuser     = out_nc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (move) begin
				out_v_q <= 1'b1;
			end else if (tready) begin
				out_v_q <= 1'b0;
			end
			if (adv) begin
				if (req.push) begin
					pend_v_q <= 1'b1;
				end else if (req.fin) begin
					pend_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_ch_q   <= pend_ch_q;
			out_last_q <= req.fin;
			out_nc_q   <= req.fin && req.nc_end;
		end
		if (adv && req.push) begin
			pend_ch_q <= req.ch;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/utf16_name_to_escaped_file_name.sv
// top level: utf-16 name to percent-escaped file name with fnv-1a hash tail when cut
//
// usage
//   s_axis carries one utf-16 code unit per item; tuser flags a valid unit
//   and tlast ends the name. m_axis carries one ascii char per item; tlast
//   marks the final char caused by an input item and tuser marks the final
//   char ('b' of ".db") of the whole file name.
//   cfg_we/cfg_wdata write the kept-char limit (reset 180, 0 acts as 1);
//   write it only while no item is in flight.
// timing
//   one item at a time: s_axis_tready is high only while the sequencer idles.
//   a unit item goes through accept, dispatch, decode, end check and flush,
//   with one step per emitted or dropped char in between (one char per plain
//   byte, three per escaped byte); a low surrogate skips the decode. the end
//   of a name adds '~' and 16 hex digits when chars were dropped, then ".db"; a
//   high surrogate still held there is replaced first. the shared escape unit
//   makes one char per cycle unless the output stalls; the hold stage keeps
//   each char until the next one or the item flush shows whether it is the last.
// reset and stalls
//   reset clears the name state, loads the hash offset basis and the limit.
//   a stalled receiver freezes the sequencer once the hold stage and output
//   register are both full; nothing is lost.
`default_nettype none
`include "utf16_name_to_escaped_file_name_defines.svh"
module utf16_name_to_escaped_file_name (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire logic [u16fn_pkg::CuW-1:0] s_axis_tdata,  // code_unit[15:0]
	input  wire logic                     s_axis_tuser,  // has_unit
	input  wire logic                     s_axis_tlast,  // end_of_name
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	output logic [u16fn_pkg::ChW-1:0]     m_axis_tdata,  // out_char[7:0]
	output logic                          m_axis_tlast,  // last_of_run
	output logic                          m_axis_tuser,  // name_complete
	input  wire logic                     cfg_we,
	input  wire logic [7:0]               cfg_wdata
);
	import u16fn_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_UNIT, S_FRESH, S_BYTE, S_END, S_TRUNC, S_HEX, S_DOT, S_D, S_B, S_FIN
	} state_t;

	state_t          state_q;
	logic [CuW-1:0]  unit_q;
	logic            end_q;
	logic            held_q;
	logic [9:0]      hs_q;
	logic [CpW-1:0]  cp_q;
	logic [1:0]      nb_q;
	logic [1:0]      bi_q;
	logic [1:0]      ci_q;
	logic            after_fresh_q;
	logic [CntW-1:0] cnt_q;
	logic [3:0]      nib_idx_q;
	logic [7:0]      lim_q;

	logic [CntW-1:0] lim;
	logic            keep;
	logic            is_hi;
	logic            is_lo;
	logic [CpW-1:0]  pair_cp;
	logic [CpW-1:0]  unit_cp;
	logic [7:0]      byte_val;
	logic [ChW-1:0]  esc_ch;
	logic            byte_done;
	logic [3:0]      nib;
	logic            adv;
	logic            pend_busy;
	logic            gated;
	out_req_t        req;
	hash_op_t        hop;

	function automatic logic [1:0] utf8_len_m1(input logic [CpW-1:0] cp);
		if (cp < 21'h80) begin
			return 2'd0;
		end else if (cp < 21'h800) begin
			return 2'd1;
		end else if (cp < 21'h10000) begin
			return 2'd2;
		end
		return 2'd3;
	endfunction

	assign lim     = (lim_q == 8'd0) ? 9'd1 : {1'b0, lim_q};
	assign keep    = cnt_q < lim;
	assign is_hi   = unit_q[15:10] == 6'b110110;
	assign is_lo   = unit_q[15:10] == 6'b110111;
	assign pair_cp = CpSuppBase + {1'b0, hs_q, unit_q[9:0]};
	assign unit_cp = {5'b0, unit_q};

	assign s_axis_tready = state_q == S_IDLE;

	u16fn_esc u_esc (
		.cp        (cp_q),
		.nb_m1     (nb_q),
		.bi        (bi_q),
		.ci        (ci_q),
		.byte_val  (byte_val),
		.ch        (esc_ch),
		.byte_done (byte_done)
	);

	u16fn_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (hop),
		.byte_val (byte_val),
		.nib      (nib)
	);

	u16fn_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.tready    (m_axis_tready),
		.adv       (adv),
		.pend_busy (pend_busy),
		.tvalid    (m_axis_tvalid),
		.tdata     (m_axis_tdata),
		.tlast     (m_axis_tlast),
		.tuser     (m_axis_tuser)
	);

	// char requests: escaped and empty-name chars go through the limit gate,
	// the suffix always goes out, the '~' and hash tail only when chars were dropped
	always_comb begin
		req        = '0;
		req.nc_end = end_q;
		gated      = 1'b0;
		case (state_q)
			S_BYTE: begin
				gated    = 1'b1;
				req.push = keep;
				req.ch   = esc_ch;
			end
			S_END: begin
				if (end_q && !held_q && cnt_q == '0) begin
					gated    = 1'b1;
					req.push = keep;
					req.ch   = ChPct;
				end
			end
			S_TRUNC: begin
				req.push = cnt_q > lim;
				req.ch   = ChTilde;
			end
			S_HEX: begin
				req.push = 1'b1;
				req.ch   = hex_char(nib);
			end
			S_DOT: begin
				req.push = 1'b1;
				req.ch   = ChDot;
			end
			S_D: begin
				req.push = 1'b1;
				req.ch   = ChD;
			end
			S_B: begin
				req.push = 1'b1;
				req.ch   = ChB;
			end
			S_FIN: begin
				req.fin = 1'b1;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	assign hop.upd = adv && state_q == S_BYTE && ci_q == 2'd0;
	assign hop.shl = adv && state_q == S_HEX;
	assign hop.clr = adv && state_q == S_B;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LimReset;
		end else if (cfg_we) begin
			lim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			unit_q        <= '0;
			end_q         <= 1'b0;
			held_q        <= 1'b0;
			hs_q          <= '0;
			cp_q          <= '0;
			nb_q          <= '0;
			bi_q          <= '0;
			ci_q          <= '0;
			after_fresh_q <= 1'b0;
			cnt_q         <= '0;
			nib_idx_q     <= '0;
		end else if (adv) begin
			// counter saturates one past the limit
			if (gated && cnt_q <= lim) begin
				cnt_q <= cnt_q + 9'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						unit_q  <= s_axis_tdata;
						end_q   <= s_axis_tlast;
						state_q <= s_axis_tuser ? S_UNIT : S_END;
					end
				end
				S_UNIT: begin
					if (held_q) begin
						held_q <= 1'b0;
						bi_q   <= '0;
						ci_q   <= '0;
						state_q <= S_BYTE;
						if (is_lo) begin
							cp_q          <= pair_cp;
							nb_q          <= utf8_len_m1(pair_cp);
							after_fresh_q <= 1'b0;
						end else begin
							// broken pair: replacement, then the unit on its own
							cp_q          <= CpRepl;
							nb_q          <= utf8_len_m1(CpRepl);
							after_fresh_q <= 1'b1;
						end
					end else begin
						state_q <= S_FRESH;
					end
				end
				S_FRESH: begin
					after_fresh_q <= 1'b0;
					bi_q          <= '0;
					ci_q          <= '0;
					if (is_hi) begin
						held_q  <= 1'b1;
						hs_q    <= unit_q[9:0];
						state_q <= S_END;
					end else if (is_lo) begin
						cp_q    <= CpRepl;
						nb_q    <= utf8_len_m1(CpRepl);
						state_q <= S_BYTE;
					end else begin
						cp_q    <= unit_cp;
						nb_q    <= utf8_len_m1(unit_cp);
						state_q <= S_BYTE;
					end
				end
				S_BYTE: begin
					if (byte_done) begin
						ci_q <= '0;
						if (bi_q == nb_q) begin
							state_q <= after_fresh_q ? S_FRESH : S_END;
						end else begin
							bi_q <= bi_q + 2'd1;
						end
					end else begin
						ci_q <= ci_q + 2'd1;
					end
				end
				S_END: begin
					if (!end_q) begin
						state_q <= S_FIN;
					end else if (held_q) begin
						// high surrogate left open at the end of the name
						held_q        <= 1'b0;
						cp_q          <= CpRepl;
						nb_q          <= utf8_len_m1(CpRepl);
						bi_q          <= '0;
						ci_q          <= '0;
						after_fresh_q <= 1'b0;
						state_q       <= S_BYTE;
					end else begin
						state_q <= S_TRUNC;
					end
				end
				S_TRUNC: begin
					nib_idx_q <= '0;
					state_q   <= (cnt_q > lim) ? S_HEX : S_DOT;
				end
				S_HEX: begin
					nib_idx_q <= nib_idx_q + 4'd1;
					if (nib_idx_q == 4'hF) begin
						state_q <= S_DOT;
					end
				end
				S_DOT: begin
					state_q <= S_D;
				end
				S_D: begin
					state_q <= S_B;
				end
				S_B: begin
					cnt_q   <= '0;
					held_q  <= 1'b0;
					hs_q    <= '0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`U16FN_ASSERT_IMP(a_idle_hold_empty, state_q == S_IDLE, !pend_busy)
	`U16FN_ASSERT_IMP(a_complete_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`U16FN_ASSERT_IMP(a_complete_is_b, m_axis_tvalid && m_axis_tuser, m_axis_tdata == ChB)
	`U16FN_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`U16FN_ASSERT_IMP(a_tail_no_held, state_q == S_HEX, !held_q)
endmodule
`default_nettype wire
